@@ hw/rtl/gray_histogram_rebin_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the gray histogram rebin core
// Shared concurrent check forms, clocked on the rising edge, held off in reset.
// ----------------------------------------------------------------------------
`ifndef GRAY_HISTOGRAM_REBIN_CORE_MACROS_SVH
`define GRAY_HISTOGRAM_REBIN_CORE_MACROS_SVH

// same-cycle implication
`define GHR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ghr check failed");

// next-cycle implication
`define GHR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ghr check failed");

`endif

@@ hw/rtl/ghr_pkg.sv @@
// ----------------------------------------------------------------------------
// ghr_pkg
// Types, constants and helper functions of the gray histogram rebin core.
// ----------------------------------------------------------------------------
package ghr_pkg;

   localparam int LEVELS  = 256;
   localparam int LEVEL_W = 8;
   localparam int COUNT_W = 23;
   localparam int WIDTH_W = 9;

   localparam logic [COUNT_W-1:0] MAX_COUNT = 23'd4194304;
   localparam logic [LEVEL_W-1:0] LEVEL_LAST = LEVEL_W'(LEVELS - 1);

   typedef logic [1:0] op_type;

   localparam op_type OP_CLEAR   = 2'd0;
   localparam op_type OP_PIXEL   = 2'd1;
   localparam op_type OP_SUMMARY = 2'd2;
   localparam op_type OP_READ    = 2'd3;

   typedef struct packed {
      logic load;
      logic clear;
      logic pix_write;
      logic walk_start;
      logic walk_issue;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic level_last;
      logic out_free;
   } sts_type;

   function automatic logic [LEVEL_W-1:0] gray_of(input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
      logic [12:0] s;
      s = 13'(r) * 13'd11 + {1'b0, g, 4'b0000} + 13'(b) * 13'd5;
      return s[12:5];
   endfunction

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s > {1'b0, MAX_COUNT}) begin
         return MAX_COUNT;
      end
      return s[COUNT_W-1:0];
   endfunction

endpackage

@@ hw/rtl/ghr_ctrl.sv @@
// ----------------------------------------------------------------------------
// ghr_ctrl
// Sequencer: accepts one beat, steps the datapath through clear, pixel
// update or a level walk, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ghr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  ghr_pkg::op_type  req_op,
   input  ghr_pkg::sts_type sts,
   output ghr_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CLEAR  = 3'd1;
   localparam logic [2:0] S_PIX_RD = 3'd2;
   localparam logic [2:0] S_PIX_WR = 3'd3;
   localparam logic [2:0] S_WALK   = 3'd4;
   localparam logic [2:0] S_DRAIN  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               unique case (req_op) inside
                  ghr_pkg::OP_CLEAR: begin
                     state_in = S_CLEAR;
                  end
                  ghr_pkg::OP_PIXEL: begin
                     state_in = S_PIX_RD;
                  end
                  ghr_pkg::OP_SUMMARY, ghr_pkg::OP_READ: begin
                     cmd.walk_start = 1'b1;
                     state_in       = S_WALK;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = S_DONE;
         end
         S_PIX_RD: begin
            state_in = S_PIX_WR;
         end
         S_PIX_WR: begin
            cmd.pix_write = 1'b1;
            state_in      = S_DONE;
         end
         S_WALK: begin
            cmd.walk_issue = 1'b1;
            if (sts.level_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/ghr_datapath.sv @@
// ----------------------------------------------------------------------------
// ghr_datapath
// Level count store with valid bits, gray conversion, rebinning walk with
// saturating bin sums, min/max tracking and the result register.
// ----------------------------------------------------------------------------
module ghr_datapath (
   input  logic             clock,
   input  logic             reset,
   input  ghr_pkg::cmd_type cmd,
   output ghr_pkg::sts_type sts,
   input  logic [1:0]       req_tuser,
   input  logic [31:0]      req_tdata,
   input  logic             csr_wr_en,
   input  logic [8:0]       csr_wr_data,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [71:0]      rsp_tdata
);

   localparam int CW = ghr_pkg::COUNT_W;
   localparam int LW = ghr_pkg::LEVEL_W;
   localparam int WW = ghr_pkg::WIDTH_W;

   logic [CW-1:0] count_mem [ghr_pkg::LEVELS];

   logic [ghr_pkg::LEVELS-1:0] valid_ff, valid_in;
   logic [CW-1:0]   mem_q_ff;
   logic            vld_q_ff;
   logic [WW-1:0]   bw_ff, bw_in;
   ghr_pkg::op_type op_ff, op_in;
   logic [LW-1:0]   idx_ff, idx_in;
   logic [LW-1:0]   gray_ff, gray_in;
   logic [LW-1:0]   level_ff, level_in;
   logic [WW-1:0]   pos_ff, pos_in;
   logic [WW-1:0]   start_ff, start_in;
   logic            proc_valid_ff, proc_valid_in;
   logic            proc_first_ff, proc_first_in;
   logic            proc_last_ff, proc_last_in;
   logic [WW-1:0]   proc_start_ff, proc_start_in;
   logic [CW-1:0]   acc_ff, acc_in;
   logic [CW-1:0]   entry_ff, entry_in;
   logic [CW-1:0]   least_ff, least_in;
   logic [CW-1:0]   greatest_ff, greatest_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [71:0]     rsp_data_ff, rsp_data_in;

   logic [LW-1:0]   rd_addr;
   logic [CW-1:0]   rd_count;
   logic [CW-1:0]   bin_sum;
   logic [WW-1:0]   w_eff;
   logic            bin_end;
   logic [CW-1:0]   out_entry, out_least, out_greatest;

   assign w_eff    = (bw_ff == '0) ? WW'(1) : bw_ff;
   assign rd_addr  = cmd.walk_issue ? level_ff : gray_ff;
   assign rd_count = vld_q_ff ? mem_q_ff : '0;
   assign bin_sum  = proc_first_ff ? rd_count : ghr_pkg::sat_add(acc_ff, rd_count);
   assign bin_end  = (pos_ff == (w_eff - WW'(1))) || (level_ff == ghr_pkg::LEVEL_LAST);

   assign sts.level_last = (level_ff == ghr_pkg::LEVEL_LAST);
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign out_entry    = (op_ff == ghr_pkg::OP_READ) ? entry_ff : '0;
   assign out_least    = (op_ff == ghr_pkg::OP_SUMMARY && w_eff == WW'(1)) ? least_ff : '0;
   assign out_greatest = (op_ff == ghr_pkg::OP_SUMMARY) ? greatest_ff : '0;

   always_comb begin
      bw_in         = csr_wr_en ? csr_wr_data : bw_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      gray_in       = gray_ff;
      level_in      = level_ff;
      pos_in        = pos_ff;
      start_in      = start_ff;
      acc_in        = acc_ff;
      entry_in      = entry_ff;
      least_in      = least_ff;
      greatest_in   = greatest_ff;
      valid_in      = valid_ff;
      proc_valid_in = cmd.walk_issue;
      proc_first_in = (pos_ff == '0);
      proc_last_in  = bin_end;
      proc_start_in = start_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (cmd.load) begin
         op_in   = req_tuser;
         idx_in  = req_tdata[31:24];
         gray_in = ghr_pkg::gray_of(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
      end
      if (cmd.clear) begin
         valid_in = '0;
      end
      if (cmd.pix_write) begin
         valid_in[gray_ff] = 1'b1;
      end
      if (cmd.walk_start) begin
         level_in    = '0;
         pos_in      = '0;
         start_in    = '0;
         entry_in    = '0;
         least_in    = ghr_pkg::MAX_COUNT;
         greatest_in = '0;
      end
      if (cmd.walk_issue) begin
         level_in = level_ff + LW'(1);
         if (bin_end) begin
            pos_in   = '0;
            start_in = {1'b0, level_ff} + WW'(1);
         end else begin
            pos_in = pos_ff + WW'(1);
         end
      end
      if (proc_valid_ff) begin
         acc_in = bin_sum;
         if (proc_last_ff) begin
            if (bin_sum < least_ff) begin
               least_in = bin_sum;
            end
            if (bin_sum > greatest_ff) begin
               greatest_in = bin_sum;
            end
         end
         if (proc_start_ff == {1'b0, idx_ff}) begin
            entry_in = ghr_pkg::sat_add(entry_ff, rd_count);
         end
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, out_greatest, out_least, out_entry};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pix_write) begin
         count_mem[gray_ff] <= ghr_pkg::sat_add(rd_count, CW'(1));
      end
      mem_q_ff <= count_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         vld_q_ff      <= 1'b0;
         bw_ff         <= WW'(1);
         proc_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         vld_q_ff      <= valid_ff[rd_addr];
         bw_ff         <= bw_in;
         proc_valid_ff <= proc_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      gray_ff       <= gray_in;
      level_ff      <= level_in;
      pos_ff        <= pos_in;
      start_ff      <= start_in;
      proc_first_ff <= proc_first_in;
      proc_last_ff  <= proc_last_in;
      proc_start_ff <= proc_start_in;
      acc_ff        <= acc_in;
      entry_ff      <= entry_in;
      least_ff      <= least_in;
      greatest_ff   <= greatest_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hw/rtl/gray_histogram_rebin_core.sv @@
// Summary and read walk all 256 levels through the single store read port,
// one level per cycle, then drain the registered read.
// One beat in flight; the next beat is taken the cycle after the result is
// registered, while that result still waits on rsp_tready.
// Synchronous reset: counts read zero at once through per-level valid bits,
// bin_width returns to 1; no clearing pass.
// ----------------------------------------------------------------------------
// gray_histogram_rebin_core
// 256-level gray histogram of streamed RGB pixels with a rebinned read view
// and min/max summary; the min is reported only at bin width 1.
// ----------------------------------------------------------------------------
`include "gray_histogram_rebin_core_macros.svh"

module gray_histogram_rebin_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red[7:0], green[15:8], blue[23:16], entry_index[31:24]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // entry_count[22:0], least_count[45:23],
                                    // greatest_count[68:46], zero fill [71:69]
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);

   ghr_pkg::cmd_type cmd;
   ghr_pkg::sts_type sts;

   ghr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   ghr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   `GHR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `GHR_ASSERT_IMPLIES(a_min_le_max, clock, reset, rsp_tvalid, rsp_tdata[45:23] <= rsp_tdata[68:46])
   `GHR_ASSERT_IMPLIES(a_entry_capped, clock, reset, rsp_tvalid, rsp_tdata[22:0] <= ghr_pkg::MAX_COUNT)

endmodule
